// ----- design/idq_pkg.sv -----
// idq_pkg: shared command and status codes, control structs and defaults
// for the input-restricted deque. No dependencies.
package idq_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int WORD_W    = 32;

    // command codes
    localparam logic [1:0] CMD_INSERT    = 2'd0;
    localparam logic [1:0] CMD_DEL_FRONT = 2'd1;
    localparam logic [1:0] CMD_DEL_REAR  = 2'd2;
    localparam logic [1:0] CMD_TRAVERSE  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_UNDF  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // store read address select
    typedef enum logic [1:0] {
        RD_HEAD,
        RD_TAIL,
        RD_NEXT
    } t_rd_sel;

    // controller -> datapath
    typedef struct packed {
        logic       ins;
        logic       del_front;
        logic       del_rear;
        logic       trav_start;
        logic       trav_adv;
        logic       rd_en;
        t_rd_sel    rd_sel;
        logic       load_code;
        logic [1:0] code;
        logic       load_word;
        logic       word_last;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic idx_is_tail;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- design/idq_ctrl.sv -----
// idq_ctrl: command sequencer for the deque.
// Depends on idq_pkg (codes and command/status structs).
module idq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_cmd,
    input  idq_pkg::t_dp_stat  i_stat,
    output idq_pkg::t_dp_cmd   o_dp_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEL_OUT,
        S_TRAV_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = !((r_state == S_IDLE) && i_stat.out_free);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        o_dp_cmd        = '0;
        o_dp_cmd.rd_sel = idq_pkg::RD_HEAD;
        n_state         = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        idq_pkg::CMD_INSERT: begin
                            o_dp_cmd.load_code = 1'b1;
                            if (i_stat.full) begin
                                o_dp_cmd.code = idq_pkg::ST_OVF;
                            end else begin
                                o_dp_cmd.ins  = 1'b1;
                                o_dp_cmd.code = idq_pkg::ST_OK;
                            end
                        end
                        idq_pkg::CMD_DEL_FRONT: begin
                            if (i_stat.empty) begin
                                o_dp_cmd.load_code = 1'b1;
                                o_dp_cmd.code      = idq_pkg::ST_UNDF;
                            end else begin
                                o_dp_cmd.del_front = 1'b1;
                                o_dp_cmd.rd_en     = 1'b1;
                                o_dp_cmd.rd_sel    = idq_pkg::RD_HEAD;
                                n_state            = S_DEL_OUT;
                            end
                        end
                        idq_pkg::CMD_DEL_REAR: begin
                            if (i_stat.empty) begin
                                o_dp_cmd.load_code = 1'b1;
                                o_dp_cmd.code      = idq_pkg::ST_UNDF;
                            end else begin
                                o_dp_cmd.del_rear = 1'b1;
                                o_dp_cmd.rd_en    = 1'b1;
                                o_dp_cmd.rd_sel   = idq_pkg::RD_TAIL;
                                n_state           = S_DEL_OUT;
                            end
                        end
                        idq_pkg::CMD_TRAVERSE: begin
                            if (i_stat.empty) begin
                                o_dp_cmd.load_code = 1'b1;
                                o_dp_cmd.code      = idq_pkg::ST_EMPTY;
                            end else begin
                                o_dp_cmd.trav_start = 1'b1;
                                o_dp_cmd.rd_en      = 1'b1;
                                o_dp_cmd.rd_sel     = idq_pkg::RD_HEAD;
                                n_state             = S_TRAV_OUT;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_DEL_OUT: begin
                if (i_stat.out_free) begin
                    o_dp_cmd.load_word = 1'b1;
                    o_dp_cmd.word_last = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_TRAV_OUT: begin
                if (i_stat.out_free) begin
                    o_dp_cmd.load_word = 1'b1;
                    o_dp_cmd.word_last = i_stat.idx_is_tail;
                    if (i_stat.idx_is_tail) begin
                        n_state = S_IDLE;
                    end else begin
                        // fetch the following word in the same edge
                        o_dp_cmd.trav_adv = 1'b1;
                        o_dp_cmd.rd_en    = 1'b1;
                        o_dp_cmd.rd_sel   = idq_pkg::RD_NEXT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/idq_dp.sv -----
// idq_dp: ring store, head/tail/empty state, traverse index and output register.
// Depends on idq_pkg (command/status structs, status codes).
module idq_dp #(
    parameter int DEPTH = idq_pkg::DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  idq_pkg::t_dp_cmd                 i_dp_cmd,
    output idq_pkg::t_dp_stat                o_stat,
    input  logic signed [idq_pkg::WORD_W-1:0] i_in_value,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic signed [idq_pkg::WORD_W-1:0] o_out_value,
    output logic [1:0]                       o_status,
    output logic                             o_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [idq_pkg::WORD_W-1:0] mem [DEPTH];

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic          r_empty, n_empty;
    logic [AW-1:0] r_idx, n_idx;
    logic [idq_pkg::WORD_W-1:0] r_rd_data;

    logic [AW-1:0] head_next, tail_next, tail_prev, idx_next;
    logic [AW-1:0] wr_addr, rd_addr;
    logic          single;

    assign head_next = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign tail_next = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    assign tail_prev = (r_tail == '0) ? LAST_IDX : r_tail - 1'b1;
    assign idx_next  = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
    assign single    = (r_head == r_tail);

    // first insert into an empty ring restarts at slot zero
    assign wr_addr = r_empty ? '0 : tail_next;

    always_comb begin
        case (i_dp_cmd.rd_sel)
            idq_pkg::RD_HEAD: rd_addr = r_head;
            idq_pkg::RD_TAIL: rd_addr = r_tail;
            idq_pkg::RD_NEXT: rd_addr = idx_next;
            default:          rd_addr = r_head;
        endcase
    end

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_empty = r_empty;
        n_idx   = r_idx;
        if (i_dp_cmd.ins) begin
            n_head  = r_empty ? '0 : r_head;
            n_tail  = wr_addr;
            n_empty = 1'b0;
        end
        if (i_dp_cmd.del_front || i_dp_cmd.del_rear) begin
            if (single) begin
                n_head  = '0;
                n_tail  = '0;
                n_empty = 1'b1;
            end else if (i_dp_cmd.del_front) begin
                n_head = head_next;
            end else begin
                n_tail = tail_prev;
            end
        end
        if (i_dp_cmd.trav_start) begin
            n_idx = r_head;
        end else if (i_dp_cmd.trav_adv) begin
            n_idx = idx_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
    end

    // ring store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.ins) begin
            mem[wr_addr] <= i_in_value;
        end
        if (i_dp_cmd.rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_dp_cmd.load_code || i_dp_cmd.load_word) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load_code) begin
            o_out_value <= '0;
            o_status    <= i_dp_cmd.code;
            o_last      <= 1'b1;
        end else if (i_dp_cmd.load_word) begin
            o_out_value <= r_rd_data;
            o_status    <= idq_pkg::ST_OK;
            o_last      <= i_dp_cmd.word_last;
        end
    end

    assign o_stat.empty       = r_empty;
    assign o_stat.full        = !r_empty && (r_head == tail_next);
    assign o_stat.idx_is_tail = (r_idx == r_tail);
    assign o_stat.out_free    = !o_out_valid || !i_out_stall;

endmodule

// ----- design/input_restricted_deque.sv -----
// Input-restricted deque: words enter at the rear, leave at front or rear.
// Insert and error results are in the output register in the cycle after acceptance;
// deletes and the first traversed word pass the registered store read first.
// One item at a time: a delete or traverse holds the input until its last word is
// loaded into the output register; a stalled result holds the input as well.
// Reset: head/tail to zero, deque empty, output register empty; store not cleared.
module input_restricted_deque #(
    parameter int DEPTH = idq_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_cmd,
    input  logic signed [idq_pkg::WORD_W-1:0] i_in_value,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [idq_pkg::WORD_W-1:0] o_out_value,
    output logic [1:0]                        o_status,
    output logic                              o_last
);

    idq_pkg::t_dp_cmd  dp_cmd;
    idq_pkg::t_dp_stat dp_stat;

    // sequencer: decodes each item, steps deletes and traverses
    idq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_cmd      (i_cmd),
        .i_stat     (dp_stat),
        .o_dp_cmd   (dp_cmd)
    );

    // store, pointers and the result register
    idq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dp_cmd    (dp_cmd),
        .o_stat      (dp_stat),
        .i_in_value  (i_in_value),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_value (o_out_value),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule
